[sv/prf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and register codes for the root frequency vector block.
// No dependencies; used by prf_lane, prf_qdiv and the top level.
package prf_pkg;

    localparam int MAX_POP    = 10;
    localparam int NUM_BASES  = 4;
    localparam int NUM_LANES  = 6;
    localparam int LANE_DEPTH = MAX_POP - 1;
    localparam int LANE_IDX_W = $clog2(LANE_DEPTH);
    localparam int LANE_SEL_W = $clog2(NUM_LANES);
    localparam int POP_W      = 4;
    localparam int IDX_W      = 6;
    localparam int FREQ_W     = 32;
    localparam int RATE_W     = 32;
    localparam int TERM_W     = 32;
    localparam int SUM_W      = 40;
    localparam int LANE_SUM_W = TERM_W + $clog2(LANE_DEPTH);
    localparam int CFG_IDX_W  = 3;

    // small dividers: 32 quotient bits, two per cycle
    localparam int DIV_BITS   = 32;
    localparam int DIV_CYCLES = DIV_BITS / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_C = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_G = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_T = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POLY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POP    = 3'd5;

    // base pairs in output order: AC AG AT CG CT GT
    localparam int PAIR_X [NUM_LANES] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_Y [NUM_LANES] = '{1, 2, 3, 2, 3, 3};

    typedef struct packed {
        logic                  done;
        logic [LANE_SUM_W-1:0] sum;
        logic [TERM_W-1:0]     term;
    } prf_lane_stat_t;

    function automatic logic [POP_W-1:0] clamp_pop(input logic [POP_W-1:0] n);
        logic [POP_W-1:0] r;
        r = n;
        if (n < POP_W'(2))
            r = POP_W'(2);
        else if (n > POP_W'(MAX_POP))
            r = POP_W'(MAX_POP);
        return r;
    endfunction

endpackage

[sv/prf_lane.sv]
`timescale 1ns / 1ps
// One base-pair lane: rate products, per-count small divisions, term store and lane sum.
// Depends on prf_pkg.
module prf_lane (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [prf_pkg::POP_W-1:0]      pop_n,
    input  logic [prf_pkg::FREQ_W-1:0]     freq_x,
    input  logic [prf_pkg::FREQ_W-1:0]     freq_y,
    input  logic [prf_pkg::RATE_W-1:0]     rate_xy,
    input  logic [prf_pkg::RATE_W-1:0]     rate_yx,
    input  logic [prf_pkg::LANE_IDX_W-1:0] rd_addr,
    output prf_pkg::prf_lane_stat_t        stat
);

    typedef enum logic [1:0] {L_IDLE, L_LOAD, L_DIV, L_WRITE} lane_state_t;

    lane_state_t                        state_reg;
    logic                               done_reg;
    logic [prf_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [prf_pkg::POP_W-1:0]          n_reg;
    logic [prf_pkg::POP_W-1:0]          f_reg;
    logic [63:0]                        prod_x_reg;
    logic [63:0]                        prod_y_reg;
    logic [prf_pkg::DIV_BITS-1:0]       dx_reg;
    logic [prf_pkg::DIV_BITS-1:0]       dy_reg;
    logic [prf_pkg::POP_W-1:0]          rx_reg;
    logic [prf_pkg::POP_W-1:0]          ry_reg;
    logic [prf_pkg::LANE_SUM_W-1:0]     sum_reg;
    logic [prf_pkg::TERM_W-1:0]         term_rd_reg;
    logic [prf_pkg::TERM_W-1:0]         term_mem [prf_pkg::LANE_DEPTH];

    logic [prf_pkg::POP_W-1:0]          dvx;
    logic [prf_pkg::TERM_W-1:0]         term;
    logic [prf_pkg::LANE_IDX_W-1:0]     wr_addr;

    // two restoring steps on a small divisor
    function automatic logic [prf_pkg::POP_W+prf_pkg::DIV_BITS-1:0] step2(
        input logic [prf_pkg::DIV_BITS-1:0] dq,
        input logic [prf_pkg::POP_W-1:0]    rem,
        input logic [prf_pkg::POP_W-1:0]    d
    );
        logic [prf_pkg::DIV_BITS-1:0] q;
        logic [prf_pkg::POP_W-1:0]    r;
        logic [prf_pkg::POP_W:0]      t;
        q = dq;
        r = rem;
        for (int i = 0; i < 2; i++) begin
            t = {r, q[prf_pkg::DIV_BITS-1]};
            q = {q[prf_pkg::DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                q[0] = 1'b1;
            end
            r = t[prf_pkg::POP_W-1:0];
        end
        return {r, q};
    endfunction

    assign dvx     = n_reg - f_reg;
    assign term    = dy_reg + dx_reg;
    assign wr_addr = prf_pkg::LANE_IDX_W'(f_reg - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (start)
                        state_reg <= L_LOAD;
                end
                L_LOAD: state_reg <= L_DIV;
                L_DIV: begin
                    if (cnt_reg == prf_pkg::DIV_CNT_W'(prf_pkg::DIV_CYCLES - 1))
                        state_reg <= L_WRITE;
                end
                L_WRITE: begin
                    if (f_reg == n_reg - 1'b1) begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end else begin
                        state_reg <= L_LOAD;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    // floor(floor(p/f)/2^33) == floor((p>>33)/f), so only the top 31 bits are divided
    always_ff @(posedge aclk) begin
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    prod_y_reg <= freq_y * rate_yx;
                    prod_x_reg <= freq_x * rate_xy;
                    n_reg      <= pop_n;
                    f_reg      <= prf_pkg::POP_W'(1);
                    sum_reg    <= '0;
                end
            end
            L_LOAD: begin
                dy_reg  <= {1'b0, prod_y_reg[63:33]};
                dx_reg  <= {1'b0, prod_x_reg[63:33]};
                ry_reg  <= '0;
                rx_reg  <= '0;
                cnt_reg <= '0;
            end
            L_DIV: begin
                {ry_reg, dy_reg} <= step2(dy_reg, ry_reg, f_reg);
                {rx_reg, dx_reg} <= step2(dx_reg, rx_reg, dvx);
                cnt_reg          <= cnt_reg + 1'b1;
            end
            L_WRITE: begin
                term_mem[wr_addr] <= term;
                sum_reg           <= sum_reg + prf_pkg::LANE_SUM_W'(term);
                f_reg             <= f_reg + 1'b1;
            end
            default: ;
        endcase
        term_rd_reg <= term_mem[rd_addr];
    end

    assign stat.done = done_reg;
    assign stat.sum  = sum_reg;
    assign stat.term = term_rd_reg;

endmodule

[sv/prf_qdiv.sv]
`timescale 1ns / 1ps
// Iterative restoring divider for the rescale: 64-bit dividend, 40-bit divisor,
// 32-bit quotient, two bits per cycle. Depends on prf_pkg.
module prf_qdiv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [63:0]                   dividend,
    input  logic [prf_pkg::SUM_W-1:0]     divisor,
    output logic                          done,
    output logic [prf_pkg::DIV_BITS-1:0]  quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [prf_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [prf_pkg::SUM_W-1:0]       rem_reg;
    logic [prf_pkg::DIV_BITS-1:0]    lo_reg;
    logic [prf_pkg::SUM_W-1:0]       rem_next;
    logic [prf_pkg::DIV_BITS-1:0]    lo_next;

    always_comb begin
        logic [prf_pkg::SUM_W:0] t;
        rem_next = rem_reg;
        lo_next  = lo_reg;
        for (int i = 0; i < 2; i++) begin
            t       = {rem_next, lo_next[prf_pkg::DIV_BITS-1]};
            lo_next = {lo_next[prf_pkg::DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
                t          = t - {1'b0, divisor};
                lo_next[0] = 1'b1;
            end
            rem_next = t[prf_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg &&
                         cnt_reg == prf_pkg::DIV_CNT_W'(prf_pkg::DIV_CYCLES - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // quotient fits 32 bits, so the top half is already below the divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= prf_pkg::SUM_W'(dividend[63:32]);
            lo_reg  <= dividend[31:0];
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

[sv/pomo_root_frequency_vector_core.sv]
`timescale 1ns / 1ps
// Root frequency vector top level: config registers, six pair lanes, merge/rescale sequencer.
// Depends on prf_pkg, prf_lane, prf_qdiv.
// The first entry is registered in S_MONO_MUL after the transaction; each item then waits
//   out the lane dividers and the rescale divider, plus any output stalls.
// Throughput: one item at a time; the lane divider loop (waited on in S_WAIT after the four
//   monoallelic entries) and the shared rescale divider set the pace.
// Reset: synchronous active-low; config returns to reset values, no clearing pass.
module pomo_root_frequency_vector_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [prf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_a_to_c,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_a_to_g,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_a_to_t,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_c_to_a,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_c_to_g,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_c_to_t,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_g_to_a,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_g_to_c,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_g_to_t,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_t_to_a,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_t_to_c,
    input  logic [prf_pkg::RATE_W-1:0]         s_rate_t_to_g,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [prf_pkg::IDX_W-1:0]          m_state_index,
    output logic [prf_pkg::FREQ_W-1:0]         m_frequency,
    output logic                               m_last
);

    typedef enum logic [2:0] {
        S_IDLE, S_MONO_MUL, S_OUT, S_WAIT, S_SUM, S_BI_RD, S_BI_MUL, S_BI_START
    } core_state_t;

    core_state_t                       state_reg;
    logic [prf_pkg::FREQ_W-1:0]        freq_reg [prf_pkg::NUM_BASES];
    logic [prf_pkg::FREQ_W-1:0]        poly_reg;
    logic [prf_pkg::POP_W-1:0]         pop_reg;
    logic [prf_pkg::POP_W-1:0]         n_reg;
    logic [1:0]                        b_reg;
    logic [prf_pkg::LANE_SEL_W-1:0]    l_reg;
    logic [prf_pkg::LANE_IDX_W-1:0]    fi_reg;
    logic                              lanes_done_reg;
    logic                              div_busy_reg;
    logic [prf_pkg::SUM_W-1:0]         sum_reg;
    logic [63:0]                       prod_reg;
    logic                              m_valid_reg;
    logic [prf_pkg::IDX_W-1:0]         idx_reg;
    logic [prf_pkg::FREQ_W-1:0]        freq_out_reg;
    logic                              last_reg;

    logic [prf_pkg::RATE_W-1:0]        rate_in [prf_pkg::NUM_BASES][prf_pkg::NUM_BASES];
    prf_pkg::prf_lane_stat_t           lane_stat [prf_pkg::NUM_LANES];
    logic [prf_pkg::NUM_LANES-1:0]     lane_done;
    logic [prf_pkg::POP_W-1:0]         pop_clamped;
    logic                              in_acc;
    logic                              out_acc;
    logic [32:0]                       one_minus;
    logic [64:0]                       mono_prod;
    logic [prf_pkg::LANE_IDX_W-1:0]    fi_last;
    logic                              bi_last;
    logic                              qdiv_start;
    logic                              qdiv_done;
    logic [prf_pkg::DIV_BITS-1:0]      quotient;
    logic [prf_pkg::IDX_W-1:0]         total_m1;

    assign pop_clamped = prf_pkg::clamp_pop(pop_reg);
    assign in_acc      = s_valid && s_ready;
    assign out_acc     = m_valid_reg && m_ready;
    assign s_ready     = (state_reg == S_IDLE);
    assign one_minus   = 33'h1_0000_0000 - {1'b0, poly_reg};
    assign mono_prod   = freq_reg[b_reg] * one_minus;
    assign fi_last     = prf_pkg::LANE_IDX_W'(n_reg - 2'd2);
    assign bi_last     = (l_reg == prf_pkg::LANE_SEL_W'(prf_pkg::NUM_LANES - 1)) &&
                         (fi_reg == fi_last);
    assign qdiv_start  = (state_reg == S_BI_START) && !div_busy_reg && (sum_reg != '0);
    assign total_m1    = prf_pkg::IDX_W'(prf_pkg::NUM_LANES * (n_reg - 1'b1) + 3);

    always_comb begin
        for (int i = 0; i < prf_pkg::NUM_BASES; i++)
            rate_in[i][i] = '0;
        rate_in[0][1] = s_rate_a_to_c;  rate_in[0][2] = s_rate_a_to_g;
        rate_in[0][3] = s_rate_a_to_t;  rate_in[1][0] = s_rate_c_to_a;
        rate_in[1][2] = s_rate_c_to_g;  rate_in[1][3] = s_rate_c_to_t;
        rate_in[2][0] = s_rate_g_to_a;  rate_in[2][1] = s_rate_g_to_c;
        rate_in[2][3] = s_rate_g_to_t;  rate_in[3][0] = s_rate_t_to_a;
        rate_in[3][1] = s_rate_t_to_c;  rate_in[3][2] = s_rate_t_to_g;
    end

    for (genvar l = 0; l < prf_pkg::NUM_LANES; l++) begin : g_lane
        prf_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (in_acc),
            .pop_n   (pop_clamped),
            .freq_x  (freq_reg[prf_pkg::PAIR_X[l]]),
            .freq_y  (freq_reg[prf_pkg::PAIR_Y[l]]),
            .rate_xy (rate_in[prf_pkg::PAIR_X[l]][prf_pkg::PAIR_Y[l]]),
            .rate_yx (rate_in[prf_pkg::PAIR_Y[l]][prf_pkg::PAIR_X[l]]),
            .rd_addr (fi_reg),
            .stat    (lane_stat[l])
        );
        assign lane_done[l] = lane_stat[l].done;
    end

    prf_qdiv u_qdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (qdiv_start),
        .dividend (prod_reg),
        .divisor  (sum_reg),
        .done     (qdiv_done),
        .quotient (quotient)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < prf_pkg::NUM_BASES; i++)
                freq_reg[i] <= 32'h4000_0000;
            poly_reg <= '0;
            pop_reg  <= prf_pkg::POP_W'(prf_pkg::MAX_POP);
        end else if (cfg_we) begin
            unique case (cfg_index) inside
                prf_pkg::REG_FREQ_A, prf_pkg::REG_FREQ_C,
                prf_pkg::REG_FREQ_G, prf_pkg::REG_FREQ_T: freq_reg[cfg_index[1:0]] <= cfg_wdata;
                prf_pkg::REG_POLY:                        poly_reg <= cfg_wdata;
                prf_pkg::REG_POP:                         pop_reg  <= cfg_wdata[prf_pkg::POP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            lanes_done_reg <= 1'b0;
            div_busy_reg   <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (lane_done[0])
                lanes_done_reg <= 1'b1;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        n_reg          <= pop_clamped;
                        b_reg          <= '0;
                        idx_reg        <= '0;
                        lanes_done_reg <= 1'b0;
                        state_reg      <= S_MONO_MUL;
                    end
                end
                S_MONO_MUL: begin
                    freq_out_reg <= mono_prod[63:32];
                    last_reg     <= 1'b0;
                    m_valid_reg  <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        m_valid_reg <= 1'b0;
                        idx_reg     <= idx_reg + 1'b1;
                        if (last_reg) begin
                            state_reg <= S_IDLE;
                        end else if (idx_reg < prf_pkg::IDX_W'(3)) begin
                            b_reg     <= b_reg + 1'b1;
                            state_reg <= S_MONO_MUL;
                        end else if (idx_reg == prf_pkg::IDX_W'(3)) begin
                            state_reg <= S_WAIT;
                        end else begin
                            if (fi_reg == fi_last) begin
                                fi_reg <= '0;
                                l_reg  <= l_reg + 1'b1;
                            end else begin
                                fi_reg <= fi_reg + 1'b1;
                            end
                            state_reg <= S_BI_RD;
                        end
                    end
                end
                S_WAIT: begin
                    if (lanes_done_reg) begin
                        sum_reg   <= '0;
                        l_reg     <= '0;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    // lane sums merged one per cycle
                    sum_reg <= sum_reg + prf_pkg::SUM_W'(lane_stat[l_reg].sum);
                    if (l_reg == prf_pkg::LANE_SEL_W'(prf_pkg::NUM_LANES - 1)) begin
                        l_reg     <= '0;
                        fi_reg    <= '0;
                        state_reg <= S_BI_RD;
                    end else begin
                        l_reg <= l_reg + 1'b1;
                    end
                end
                S_BI_RD: state_reg <= S_BI_MUL;
                S_BI_MUL: begin
                    prod_reg  <= poly_reg * lane_stat[l_reg].term;
                    state_reg <= S_BI_START;
                end
                S_BI_START: begin
                    // S_BI_START doubles as the divider wait
                    if (sum_reg == '0) begin
                        freq_out_reg <= '0;
                        last_reg     <= bi_last;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_OUT;
                    end else if (!div_busy_reg) begin
                        div_busy_reg <= 1'b1;
                    end else if (qdiv_done) begin
                        div_busy_reg <= 1'b0;
                        freq_out_reg <= quotient;
                        last_reg     <= bi_last;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_state_index = idx_reg;
    assign m_frequency   = freq_out_reg;
    assign m_last        = last_reg;

    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_state_index == total_m1)
        else $error("last flag off the final index");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken while a result is pending");

    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done == '0 || lane_done == '1)
        else $error("lanes out of step");

    a_index_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !m_last |=> m_state_index == $past(m_state_index) + 1'b1)
        else $error("index did not advance");

endmodule
